### rtl/losg_pkg.sv
// Package for the line-of-sight guidance block: item types, datapath widths,
// CORDIC constants and the arctangent table. Depends on nothing.
package losg_pkg;

  localparam int ANG_W    = 24;
  localparam int HEAD_W   = 24;
  localparam int XTE_W    = 32;
  localparam int POS_W    = 32;
  localparam int DELTA_W  = 31;
  localparam int GUARD    = 4;
  localparam int ENT_W    = POS_W + 1 + GUARD;
  localparam int P1_W     = ENT_W + 4;
  localparam int P2_W     = 38;
  localparam int GAIN_LO_W = 12;
  localparam int GAIN_HI_W = 13;
  localparam int MUL_W    = P1_W + GAIN_HI_W;
  localparam int PROD_W   = P1_W + 25;
  localparam int FRAC_SH  = 24 + GUARD;
  localparam int FULL_W   = PROD_W - FRAC_SH;

  localparam logic signed [ANG_W-1:0] HALF_PI_ANG = 24'sd1647099;
  localparam int GAIN_Q24 = 10188014;
  localparam logic signed [GAIN_HI_W-1:0] GAIN_HI = GAIN_HI_W'(GAIN_Q24 >> GAIN_LO_W);
  localparam logic signed [GAIN_HI_W-1:0] GAIN_LO =
    GAIN_HI_W'(GAIN_Q24 % (1 << GAIN_LO_W));
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (FRAC_SH - 1));
  localparam logic [DELTA_W-1:0] DELTA_RESET = 31'd655360;

  typedef struct packed {
    logic signed [POS_W-1:0] vessel_north;
    logic signed [POS_W-1:0] vessel_east;
    logic signed [POS_W-1:0] path_point_north;
    logic signed [POS_W-1:0] path_point_east;
    logic signed [POS_W-1:0] tangent_north;
    logic signed [POS_W-1:0] tangent_east;
  } in_item_t;

  typedef struct packed {
    logic signed [HEAD_W-1:0] heading_reference;
    logic signed [XTE_W-1:0]  cross_track_error;
  } out_item_t;

  typedef struct packed {
    logic fallback;
    logic zero;
  } p1_side_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] psi;
    logic signed [XTE_W-1:0] ye;
    logic                    fallback;
    logic                    zero;
  } p2_side_t;

  function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0:  v = 24'sd823550;
      1:  v = 24'sd486170;
      2:  v = 24'sd256879;
      3:  v = 24'sd130396;
      4:  v = 24'sd65451;
      5:  v = 24'sd32757;
      6:  v = 24'sd16383;
      7:  v = 24'sd8192;
      8:  v = 24'sd4096;
      9:  v = 24'sd2048;
      10: v = 24'sd1024;
      11: v = 24'sd512;
      12: v = 24'sd256;
      13: v = 24'sd128;
      14: v = 24'sd64;
      15: v = 24'sd32;
      16: v = 24'sd16;
      17: v = 24'sd8;
      18: v = 24'sd4;
      19: v = 24'sd2;
      20: v = 24'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/los_guidance_heading_top.sv
// Throughput: one item per cycle; an output stall freezes every pipeline stage at once.
// The two CORDIC chains, one stage per micro-rotation, set the depth.
// Reset clears all valid bits and loads the lookahead distance with 10 m.
// Top level of the line-of-sight guidance block; instantiates losg_path_cordic,
// losg_gain_scale and losg_lead_cordic and uses losg_pkg.
module los_guidance_heading_top #(
  parameter int CORDIC_STEPS = 20
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  losg_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output losg_pkg::out_item_t                out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [losg_pkg::DELTA_W-1:0]       cfg_data
);

  logic                               en;
  logic [losg_pkg::DELTA_W-1:0]       lookahead;

  logic                               p1_valid;
  logic signed [losg_pkg::ANG_W-1:0]  p1_angle;
  logic signed [losg_pkg::P1_W-1:0]   p1_cross;
  losg_pkg::p1_side_t                 p1_side;

  logic                               gs_valid;
  losg_pkg::p2_side_t                 gs_side;

  logic                               p2_valid;
  logic signed [losg_pkg::ANG_W-1:0]  p2_angle;
  losg_pkg::p2_side_t                 p2_side;

  logic signed [losg_pkg::ANG_W-1:0]  lead_angle;
  losg_pkg::out_item_t                out_next;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lookahead <= losg_pkg::DELTA_RESET;
    end else if (cfg_valid) begin
      lookahead <= cfg_data;
    end
  end

  losg_path_cordic #(.STEPS(CORDIC_STEPS)) u_path (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .out_valid (p1_valid),
    .out_angle (p1_angle),
    .out_cross (p1_cross),
    .out_side  (p1_side)
  );

  losg_gain_scale u_gain (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p1_valid),
    .in_angle  (p1_angle),
    .in_cross  (p1_cross),
    .in_side   (p1_side),
    .out_valid (gs_valid),
    .out_side  (gs_side)
  );

  losg_lead_cordic #(.STEPS(CORDIC_STEPS)) u_lead (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (gs_valid),
    .delta     (lookahead),
    .in_side   (gs_side),
    .out_valid (p2_valid),
    .out_angle (p2_angle),
    .out_side  (p2_side)
  );

  always_comb begin
    lead_angle = p2_side.zero ? '0 : p2_angle;
    out_next.heading_reference = p2_side.fallback ? p2_side.psi : p2_side.psi - lead_angle;
    out_next.cross_track_error = p2_side.ye;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= p2_valid;
    end
  end

`ifndef SYNTHESIS
  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output valid set right after reset.");

  a_freeze_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(p1_valid) && $stable(gs_valid) && $stable(p2_valid))
    else $error("Pipeline valid bits moved while the output was stalled.");

  a_fallback_no_error: assert property (@(posedge clk) disable iff (rst)
    (gs_valid && gs_side.fallback) |-> (gs_side.ye == '0))
    else $error("Cross-track error is nonzero for a degenerate tangent.");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    (p2_valid && p2_side.zero) |-> (p2_side.ye == '0))
    else $error("Zero lookahead vector flagged with a nonzero error.");
`endif

endmodule

### rtl/losg_path_cordic.sv
// Path angle stage: error vector formation, quadrant pre-rotation and a
// pipelined vectoring CORDIC that also rotates the error vector. Uses losg_pkg.
module losg_path_cordic #(
  parameter int STEPS = 20
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  losg_pkg::in_item_t                    in_item,
  output logic                                  out_valid,
  output logic signed [losg_pkg::ANG_W-1:0]     out_angle,
  output logic signed [losg_pkg::P1_W-1:0]      out_cross,
  output losg_pkg::p1_side_t                    out_side
);

  localparam int W  = losg_pkg::P1_W;
  localparam int EW = losg_pkg::ENT_W;
  localparam int AW = losg_pkg::ANG_W;

  logic                 a_valid;
  logic                 a_fallback;
  logic signed [EW-1:0] a_x, a_y, a_cx, a_cy;
  logic signed [EW-1:0] a_x_next, a_y_next, a_cx_next, a_cy_next;
  logic                 a_fallback_next;
  logic signed [losg_pkg::POS_W:0] pv_n, pv_e, vp_n, vp_e;

  logic signed [W-1:0]  b_x, b_y, b_cx, b_cy;
  logic signed [AW-1:0] b_z;
  logic signed [W-1:0]  ex_x, ex_y, ex_cx, ex_cy;

  logic signed [W-1:0]  x_r  [0:STEPS-1];
  logic signed [W-1:0]  y_r  [0:STEPS-1];
  logic signed [W-1:0]  cx_r [0:STEPS-1];
  logic signed [W-1:0]  cy_r [0:STEPS];
  logic signed [AW-1:0] z_r  [0:STEPS];
  losg_pkg::p1_side_t   side_r [0:STEPS];
  logic                 valid_r [0:STEPS];

  always_comb begin
    pv_n = {in_item.path_point_north[31], in_item.path_point_north}
         - {in_item.vessel_north[31], in_item.vessel_north};
    pv_e = {in_item.path_point_east[31], in_item.path_point_east}
         - {in_item.vessel_east[31], in_item.vessel_east};
    vp_n = {in_item.vessel_north[31], in_item.vessel_north}
         - {in_item.path_point_north[31], in_item.path_point_north};
    vp_e = {in_item.vessel_east[31], in_item.vessel_east}
         - {in_item.path_point_east[31], in_item.path_point_east};
    a_fallback_next = (in_item.tangent_north == '0) && (in_item.tangent_east == '0);
    if (a_fallback_next) begin
      a_x_next  = {pv_n, 4'b0000};
      a_y_next  = {pv_e, 4'b0000};
      a_cx_next = '0;
      a_cy_next = '0;
    end else begin
      a_x_next  = {in_item.tangent_north[31], in_item.tangent_north, 4'b0000};
      a_y_next  = {in_item.tangent_east[31], in_item.tangent_east, 4'b0000};
      a_cx_next = {vp_n, 4'b0000};
      a_cy_next = {vp_e, 4'b0000};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x        <= a_x_next;
      a_y        <= a_y_next;
      a_cx       <= a_cx_next;
      a_cy       <= a_cy_next;
      a_fallback <= a_fallback_next;
    end
  end

  always_comb begin
    ex_x  = W'(a_x);
    ex_y  = W'(a_y);
    ex_cx = W'(a_cx);
    ex_cy = W'(a_cy);
    if (a_x[EW-1] && !a_y[EW-1]) begin
      b_x  = ex_y;
      b_y  = -ex_x;
      b_cx = ex_cy;
      b_cy = -ex_cx;
      b_z  = losg_pkg::HALF_PI_ANG;
    end else if (a_x[EW-1]) begin
      b_x  = -ex_y;
      b_y  = ex_x;
      b_cx = -ex_cy;
      b_cy = ex_cx;
      b_z  = -losg_pkg::HALF_PI_ANG;
    end else begin
      b_x  = ex_x;
      b_y  = ex_y;
      b_cx = ex_cx;
      b_cy = ex_cy;
      b_z  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]  <= b_x;
      y_r[0]  <= b_y;
      cx_r[0] <= b_cx;
      cy_r[0] <= b_cy;
      z_r[0]  <= b_z;
      side_r[0].fallback <= a_fallback;
      side_r[0].zero     <= (a_x == '0) && (a_y == '0);
    end
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_stage
    localparam logic signed [AW-1:0] ATAN = losg_pkg::atan_entry(g);
    logic up;
    assign up = !y_r[g][W-1];

    always_ff @(posedge clk) begin
      if (en) begin
        cy_r[g+1]   <= up ? cy_r[g] - (cx_r[g] >>> g) : cy_r[g] + (cx_r[g] >>> g);
        z_r[g+1]    <= up ? z_r[g] + ATAN : z_r[g] - ATAN;
        side_r[g+1] <= side_r[g];
      end
    end

    if (g < STEPS - 1) begin : g_vec
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[g+1]  <= up ? x_r[g] + (y_r[g] >>> g) : x_r[g] - (y_r[g] >>> g);
          y_r[g+1]  <= up ? y_r[g] - (x_r[g] >>> g) : y_r[g] + (x_r[g] >>> g);
          cx_r[g+1] <= up ? cx_r[g] + (cy_r[g] >>> g) : cx_r[g] - (cy_r[g] >>> g);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      for (int i = 0; i <= STEPS; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (en) begin
      a_valid    <= in_valid;
      valid_r[0] <= a_valid;
      for (int i = 1; i <= STEPS; i++) begin
        valid_r[i] <= valid_r[i-1];
      end
    end
  end

  assign out_valid = valid_r[STEPS];
  assign out_angle = z_r[STEPS];
  assign out_cross = cy_r[STEPS];
  assign out_side  = side_r[STEPS];

endmodule

### rtl/losg_gain_scale.sv
// Gain compensation of the rotated error: split constant multiply, rounding
// and saturation to the 32-bit cross-track error. Uses losg_pkg.
module losg_gain_scale (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [losg_pkg::ANG_W-1:0] in_angle,
  input  logic signed [losg_pkg::P1_W-1:0]  in_cross,
  input  losg_pkg::p1_side_t                in_side,
  output logic                              out_valid,
  output losg_pkg::p2_side_t                out_side
);

  localparam int MW = losg_pkg::MUL_W;
  localparam int PW = losg_pkg::PROD_W;
  localparam int FW = losg_pkg::FULL_W;
  localparam int XW = losg_pkg::XTE_W;

  logic                              m_valid;
  logic signed [MW-1:0]              m_hi, m_lo;
  logic signed [losg_pkg::ANG_W-1:0] m_psi;
  logic                              m_fallback;

  logic signed [PW-1:0] prod;
  logic signed [FW-1:0] full;
  logic signed [XW-1:0] ye_sat;
  logic                 ovf_pos, ovf_neg;
  losg_pkg::p2_side_t   side_next;

  always_ff @(posedge clk) begin
    if (en) begin
      m_hi       <= in_cross * losg_pkg::GAIN_HI;
      m_lo       <= in_cross * losg_pkg::GAIN_LO;
      m_psi      <= in_side.zero ? '0 : in_angle;
      m_fallback <= in_side.fallback;
    end
  end

  always_comb begin
    prod    = (PW'(m_hi) <<< losg_pkg::GAIN_LO_W) + PW'(m_lo) + losg_pkg::ROUND_HALF;
    full    = prod[PW-1:losg_pkg::FRAC_SH];
    ovf_pos = !full[FW-1] && (|full[FW-2:XW-1]);
    ovf_neg = full[FW-1] && !(&full[FW-2:XW-1]);
    if (ovf_pos) begin
      ye_sat = {1'b0, {(XW-1){1'b1}}};
    end else if (ovf_neg) begin
      ye_sat = {1'b1, {(XW-1){1'b0}}};
    end else begin
      ye_sat = full[XW-1:0];
    end
    side_next.psi      = m_psi;
    side_next.ye       = m_fallback ? '0 : ye_sat;
    side_next.fallback = m_fallback;
    side_next.zero     = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= side_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      m_valid   <= in_valid;
      out_valid <= m_valid;
    end
  end

endmodule

### rtl/losg_lead_cordic.sv
// Lookahead angle stage: pipelined vectoring CORDIC on the lookahead distance
// and cross-track error, carrying the path angle alongside. Uses losg_pkg.
module losg_lead_cordic #(
  parameter int STEPS = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [losg_pkg::DELTA_W-1:0]        delta,
  input  losg_pkg::p2_side_t                  in_side,
  output logic                                out_valid,
  output logic signed [losg_pkg::ANG_W-1:0]   out_angle,
  output losg_pkg::p2_side_t                  out_side
);

  localparam int W  = losg_pkg::P2_W;
  localparam int AW = losg_pkg::ANG_W;
  localparam int DW = losg_pkg::DELTA_W;
  localparam int XW = losg_pkg::XTE_W;
  localparam int G  = losg_pkg::GUARD;

  logic signed [W-1:0]  x_r [0:STEPS-1];
  logic signed [W-1:0]  y_r [0:STEPS-1];
  logic signed [AW-1:0] z_r [1:STEPS];
  losg_pkg::p2_side_t   side_r [0:STEPS];
  logic                 valid_r [0:STEPS];
  losg_pkg::p2_side_t   side_next;

  always_comb begin
    side_next      = in_side;
    side_next.zero = (delta == '0) && (in_side.ye == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= {{(W-DW-G){1'b0}}, delta, {G{1'b0}}};
      y_r[0]    <= {{(W-XW-G){in_side.ye[XW-1]}}, in_side.ye, {G{1'b0}}};
      side_r[0] <= side_next;
    end
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_stage
    localparam logic signed [AW-1:0] ATAN = losg_pkg::atan_entry(g);
    logic                 up;
    logic signed [AW-1:0] z_prev;
    assign up = !y_r[g][W-1];

    if (g == 0) begin : g_first
      assign z_prev = '0;
    end else begin : g_rest
      assign z_prev = z_r[g];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        z_r[g+1]    <= up ? z_prev + ATAN : z_prev - ATAN;
        side_r[g+1] <= side_r[g];
      end
    end

    if (g < STEPS - 1) begin : g_vec
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[g+1] <= up ? x_r[g] + (y_r[g] >>> g) : x_r[g] - (y_r[g] >>> g);
          y_r[g+1] <= up ? y_r[g] - (x_r[g] >>> g) : y_r[g] + (x_r[g] >>> g);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= STEPS; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (en) begin
      valid_r[0] <= in_valid;
      for (int i = 1; i <= STEPS; i++) begin
        valid_r[i] <= valid_r[i-1];
      end
    end
  end

  assign out_valid = valid_r[STEPS];
  assign out_angle = z_r[STEPS];
  assign out_side  = side_r[STEPS];

endmodule
